// ----- sv/mtt_pkg.sv -----
// ============================================================================
// mtt_pkg
// Shared types and constants of the timer table engine.
// ============================================================================
package mtt_pkg;

    localparam int DEF_NUM_TIMERS = 16;
    localparam int DEF_TICK_WIDTH = 32;
    localparam int MAX_REPORTS    = 16;
    localparam int REP_W          = $clog2(MAX_REPORTS + 1);
    localparam int QUEUE_DEPTH    = 2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [3:0] {
        OP_TICK         = 4'd0,
        OP_INIT         = 4'd1,
        OP_START        = 4'd2,
        OP_STOP         = 4'd3,
        OP_DELETE       = 4'd4,
        OP_SET_PERIOD   = 4'd5,
        OP_SET_ONESHOT  = 4'd6,
        OP_SET_PERIODIC = 4'd7,
        OP_GET_PERIOD   = 4'd8,
        OP_GET_STATE    = 4'd9,
        OP_READ_TICK    = 4'd10
    } mtt_op_t;

    // decoded command; NOP covers unknown codes and indexes beyond the table
    typedef enum logic [3:0] {
        CODE_TICK,
        CODE_INIT,
        CODE_START,
        CODE_STOP,
        CODE_DELETE,
        CODE_SET_PERIOD,
        CODE_SET_ONESHOT,
        CODE_SET_PERIODIC,
        CODE_GET_PERIOD,
        CODE_GET_STATE,
        CODE_READ_TICK,
        CODE_NOP
    } mtt_code_t;

    typedef enum logic [1:0] {
        KIND_ACK       = 2'd0,
        KIND_EXPIRY    = 2'd1,
        KIND_IDLE_TICK = 2'd2
    } mtt_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMD,
        ST_SCAN,
        ST_FIN
    } mtt_state_t;

    typedef struct packed {
        mtt_code_t   code;
        logic [3:0]  index;
        logic [31:0] value;
        logic        mode;
    } mtt_cmd_t;

endpackage

// ----- sv/mtt_if.sv -----
// ============================================================================
// mtt_if
// Valid/ready channels of the timer table engine: command in, result out.
// ============================================================================
interface mtt_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic [3:0]  timer_index;
    logic [31:0] value;
    logic        periodic_mode;

    modport source (output valid, operation, timer_index, value, periodic_mode,
                    input ready);
    modport sink   (input valid, operation, timer_index, value, periodic_mode,
                    output ready);
endinterface

interface mtt_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  timer_index_res;
    logic [31:0] read_value;
    logic        status;
    logic        last;

    modport source (output valid, kind, timer_index_res, read_value, status, last,
                    input ready);
    modport sink   (input valid, kind, timer_index_res, read_value, status, last,
                    output ready);
endinterface

// ----- sv/multi_timer_table_engine.sv -----
// ============================================================================
// multi_timer_table_engine
// Table of software timers driven by tick and command beats.
// ============================================================================
// Commands enter a two-entry queue and are carried out one at a time. A
// tick scans the table, reading one timer entry per cycle while the scan
// is not held, through the single read port of the period and deadline
// memories, so scan length grows with the table. A result stalled at the
// output holds the scan only when a further expiry has to be reported.
module multi_timer_table_engine
    import mtt_pkg::*;
#(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS,
    parameter int TICK_WIDTH = DEF_TICK_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    mtt_cmd_if.sink   cmd,
    mtt_res_if.source res
);

    logic     q_valid;
    mtt_cmd_t q_data;
    logic     q_pop;

    mtt_front #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    mtt_back #(
        .NUM_TIMERS (NUM_TIMERS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

// ----- sv/mtt_front.sv -----
// ============================================================================
// mtt_front
// Accepts command beats, decodes them and holds them in a short queue.
// ============================================================================
module mtt_front
    import mtt_pkg::*;
#(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS
)
(
    input  logic     clk,
    input  logic     rst_n,
    mtt_cmd_if.sink  cmd,
    output logic     q_valid,
    output mtt_cmd_t q_data,
    input  logic     q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    mtt_cmd_t           q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    mtt_cmd_t           decoded;
    logic               in_range;
    logic               push;

    assign in_range = ({28'd0, cmd.timer_index} < 32'(NUM_TIMERS));

    always_comb
    begin
        decoded.index = cmd.timer_index;
        decoded.value = cmd.value;
        decoded.mode  = cmd.periodic_mode;
        case (cmd.operation)
            OP_TICK:         decoded.code = CODE_TICK;
            OP_READ_TICK:    decoded.code = CODE_READ_TICK;
            OP_INIT:         decoded.code = in_range ? CODE_INIT         : CODE_NOP;
            OP_START:        decoded.code = in_range ? CODE_START        : CODE_NOP;
            OP_STOP:         decoded.code = in_range ? CODE_STOP         : CODE_NOP;
            OP_DELETE:       decoded.code = in_range ? CODE_DELETE       : CODE_NOP;
            OP_SET_PERIOD:   decoded.code = in_range ? CODE_SET_PERIOD   : CODE_NOP;
            OP_SET_ONESHOT:  decoded.code = in_range ? CODE_SET_ONESHOT  : CODE_NOP;
            OP_SET_PERIODIC: decoded.code = in_range ? CODE_SET_PERIODIC : CODE_NOP;
            OP_GET_PERIOD:   decoded.code = in_range ? CODE_GET_PERIOD   : CODE_NOP;
            OP_GET_STATE:    decoded.code = in_range ? CODE_GET_STATE    : CODE_NOP;
            default:         decoded.code = CODE_NOP;
        endcase
    end

    assign cmd.ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (count_reg != '0);
    assign q_data    = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ----- sv/mtt_back.sv -----
// ============================================================================
// mtt_back
// Executes queued commands against the timer table and scans it on ticks.
// ============================================================================
module mtt_back
    import mtt_pkg::*;
#(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS,
    parameter int TICK_WIDTH = DEF_TICK_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  mtt_cmd_t  q_data,
    output logic      q_pop,
    mtt_res_if.source res
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    mtt_state_t             state_reg, state_next;
    mtt_cmd_t               cmd_reg, cmd_next;
    logic [TICK_WIDTH-1:0]  tick_reg, tick_next;
    logic [NUM_TIMERS-1:0]  active_reg, active_next;
    logic [NUM_TIMERS-1:0]  periodic_reg, periodic_next;
    logic [NUM_TIMERS-1:0]  armed_reg, armed_next;

    logic [TICK_WIDTH-1:0]  period_mem   [NUM_TIMERS];
    logic [TICK_WIDTH-1:0]  deadline_mem [NUM_TIMERS];
    logic [TICK_WIDTH-1:0]  rd_period_reg;
    logic [TICK_WIDTH-1:0]  rd_deadline_reg;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   per_we;
    logic [TICK_WIDTH-1:0]  per_wdata;
    logic                   dl_we;
    logic [IDX_W-1:0]       dl_waddr;
    logic [TICK_WIDTH-1:0]  dl_wdata;

    logic [CNT_W-1:0]       issue_reg, issue_next;
    logic                   eval_valid_reg, eval_valid_next;
    logic [IDX_W-1:0]       eval_idx_reg, eval_idx_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic [REP_W-1:0]       rep_cnt_reg, rep_cnt_next;

    logic                   out_valid_reg, out_valid_next;
    mtt_kind_t              out_kind_reg, out_kind_next;
    logic [3:0]             out_idx_reg, out_idx_next;
    logic [31:0]            out_rv_reg, out_rv_next;
    logic                   out_st_reg, out_st_next;
    logic                   out_last_reg, out_last_next;

    logic                   out_free;
    logic [IDX_W-1:0]       cmd_addr;
    logic [TICK_WIDTH-1:0]  start_sum;
    logic                   hit;
    logic                   report;
    logic                   stall;
    logic                   scan_done;

    assign out_free  = !out_valid_reg || res.ready;
    assign cmd_addr  = IDX_W'(cmd_reg.index);
    assign start_sum = tick_reg + rd_period_reg;
    assign hit       = eval_valid_reg && armed_reg[eval_idx_reg]
                       && (tick_reg >= rd_deadline_reg);
    assign report    = hit && active_reg[eval_idx_reg]
                       && (rep_cnt_reg < REP_W'(MAX_REPORTS));
    assign stall     = report && pend_valid_reg && !out_free;
    assign scan_done = !eval_valid_reg && (issue_reg == CNT_W'(NUM_TIMERS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_data.code == CODE_TICK) ? ST_SCAN : ST_CMD;
                end
            end
            ST_CMD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next        = cmd_reg;
        tick_next       = tick_reg;
        active_next     = active_reg;
        periodic_next   = periodic_reg;
        armed_next      = armed_reg;
        issue_next      = issue_reg;
        eval_valid_next = eval_valid_reg;
        eval_idx_next   = eval_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        rep_cnt_next    = rep_cnt_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_kind_next   = out_kind_reg;
        out_idx_next    = out_idx_reg;
        out_rv_next     = out_rv_reg;
        out_st_next     = out_st_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        per_we          = 1'b0;
        per_wdata       = TICK_WIDTH'(cmd_reg.value);
        dl_we           = 1'b0;
        dl_waddr        = cmd_addr;
        dl_wdata        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    if (q_data.code == CODE_TICK)
                    begin
                        tick_next       = tick_reg + 1'b1;
                        issue_next      = '0;
                        eval_valid_next = 1'b0;
                        pend_valid_next = 1'b0;
                        rep_cnt_next    = '0;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = IDX_W'(q_data.index);
                    end
                end
            end
            ST_CMD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ACK;
                    out_idx_next   = cmd_reg.index;
                    out_rv_next    = '0;
                    out_st_next    = STATUS_OK;
                    out_last_next  = 1'b1;
                    case (cmd_reg.code)
                        CODE_INIT:
                        begin
                            per_we                  = 1'b1;
                            dl_we                   = 1'b1;
                            dl_wdata                = '0;
                            periodic_next[cmd_addr] = cmd_reg.mode;
                            active_next[cmd_addr]   = 1'b0;
                            armed_next[cmd_addr]    = 1'b0;
                        end
                        CODE_START:
                        begin
                            dl_we                 = 1'b1;
                            dl_wdata              = start_sum;
                            active_next[cmd_addr] = 1'b1;
                            armed_next[cmd_addr]  = 1'b1;
                        end
                        CODE_STOP:
                        begin
                            if (!active_reg[cmd_addr])
                            begin
                                out_st_next = STATUS_ERR;
                            end
                            else
                            begin
                                active_next[cmd_addr] = 1'b0;
                                armed_next[cmd_addr]  = 1'b0;
                            end
                        end
                        CODE_DELETE:
                        begin
                            active_next[cmd_addr] = 1'b0;
                            armed_next[cmd_addr]  = 1'b0;
                        end
                        CODE_SET_PERIOD:   per_we = 1'b1;
                        CODE_SET_ONESHOT:  periodic_next[cmd_addr] = 1'b0;
                        CODE_SET_PERIODIC: periodic_next[cmd_addr] = 1'b1;
                        CODE_GET_PERIOD:   out_rv_next = 32'(rd_period_reg);
                        CODE_GET_STATE:    out_rv_next = 32'(active_reg[cmd_addr]);
                        CODE_READ_TICK:    out_rv_next = 32'(tick_reg);
                        default:           out_rv_next = '0;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    if (hit)
                    begin
                        if (periodic_reg[eval_idx_reg])
                        begin
                            dl_we                     = 1'b1;
                            dl_waddr                  = eval_idx_reg;
                            dl_wdata                  = start_sum;
                            active_next[eval_idx_reg] = 1'b1;
                        end
                        else
                        begin
                            active_next[eval_idx_reg] = 1'b0;
                        end
                    end
                    // the held expiry is known not to be last once another one shows up
                    if (report)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_EXPIRY;
                            out_idx_next   = 4'(pend_idx_reg);
                            out_rv_next    = '0;
                            out_st_next    = STATUS_OK;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = eval_idx_reg;
                        rep_cnt_next    = rep_cnt_reg + 1'b1;
                    end
                    if (issue_reg != CNT_W'(NUM_TIMERS))
                    begin
                        rd_en           = 1'b1;
                        rd_addr         = issue_reg[IDX_W-1:0];
                        eval_valid_next = 1'b1;
                        eval_idx_next   = issue_reg[IDX_W-1:0];
                        issue_next      = issue_reg + 1'b1;
                    end
                    else
                    begin
                        eval_valid_next = 1'b0;
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = pend_valid_reg ? KIND_EXPIRY : KIND_IDLE_TICK;
                    out_idx_next    = pend_valid_reg ? 4'(pend_idx_reg) : 4'd0;
                    out_rv_next     = '0;
                    out_st_next     = STATUS_OK;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tick_reg       <= '0;
            active_reg     <= '0;
            periodic_reg   <= '0;
            armed_reg      <= '0;
            issue_reg      <= '0;
            eval_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            rep_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            active_reg     <= active_next;
            periodic_reg   <= periodic_next;
            armed_reg      <= armed_next;
            issue_reg      <= issue_next;
            eval_valid_reg <= eval_valid_next;
            pend_valid_reg <= pend_valid_next;
            rep_cnt_reg    <= rep_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        eval_idx_reg  <= eval_idx_next;
        pend_idx_reg  <= pend_idx_next;
        out_kind_reg  <= out_kind_next;
        out_idx_reg   <= out_idx_next;
        out_rv_reg    <= out_rv_next;
        out_st_reg    <= out_st_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (per_we)
        begin
            period_mem[cmd_addr] <= per_wdata;
        end
        if (dl_we)
        begin
            deadline_mem[dl_waddr] <= dl_wdata;
        end
        if (rd_en)
        begin
            rd_period_reg   <= period_mem[rd_addr];
            rd_deadline_reg <= deadline_mem[rd_addr];
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.kind            = out_kind_reg;
    assign res.timer_index_res = out_idx_reg;
    assign res.read_value      = out_rv_reg;
    assign res.status          = out_st_reg;
    assign res.last            = out_last_reg;

`ifndef NO_ASSERTIONS
    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && q_valid && q_data.code == CODE_TICK)
        |=> (tick_reg == TICK_WIDTH'($past(tick_reg) + 1'b1)))
        else $error("tick counter did not advance by one");

    a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        eval_valid_reg |-> (state_reg == ST_SCAN))
        else $error("scan entry pending outside scan");

    a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (rep_cnt_reg != '0 && rep_cnt_reg <= REP_W'(MAX_REPORTS)))
        else $error("held expiry without report count");

    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_free) |=> (!pend_valid_reg && out_valid_reg && out_last_reg))
        else $error("tick finished without a closing beat");
`endif

endmodule

// ----- bench/tb_multi_timer_table_engine.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_multi_timer_table_engine
// Self-checking bench for the timer table engine.
// ============================================================================
// A directed table covers reset values, wrap of the deadline sum, period
// extremes, failed stops and unknown codes. Random commands and ticks follow
// in three idle patterns, including a burst where all timers fire on one
// tick and a long output hold that backs up the command queue. All results
// are checked in order against directed rows or a local model of the table.
module tb_multi_timer_table_engine;
    import mtt_pkg::*;

    localparam int NUM_TIMERS     = DEF_NUM_TIMERS;
    localparam int RESET_CYCLES   = 6;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 2 * NUM_TIMERS + 8;
    localparam logic [3:0] OP_UNUSED_LO = 4'd11;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [3:0]  op;
        logic [3:0]  index;
        logic [31:0] value;
        logic        mode;
    } cmd_beat_t;

    typedef struct packed {
        mtt_kind_t   kind;
        logic [3:0]  index;
        logic [31:0] read_value;
        logic        status;
        logic        last;
    } timer_result_t;

    // op, index, value, mode, typed, kind, read_value, status
    typedef struct packed {
        logic [3:0]  op;
        logic [3:0]  index;
        logic [31:0] value;
        logic        mode;
        logic        typed;
        mtt_kind_t   kind;
        logic [31:0] read_value;
        logic        status;
    } stim_row_t;

    localparam int NUM_ROWS = 27;
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{OP_READ_TICK,    4'd0,  32'h0,         1'b0, 1'b1, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_TICK,         4'd0,  32'h0,         1'b0, 1'b1, KIND_IDLE_TICK, 32'h0, STATUS_OK},
        '{OP_READ_TICK,    4'd9,  32'hFFFF_FFFF, 1'b1, 1'b1, KIND_ACK,       32'h1, STATUS_OK},
        '{OP_GET_STATE,    4'd15, 32'h0,         1'b0, 1'b1, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_STOP,         4'd3,  32'h0,         1'b0, 1'b1, KIND_ACK,       32'h0, STATUS_ERR},
        '{OP_INIT,         4'd0,  32'hFFFF_FFFF, 1'b0, 1'b1, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_GET_PERIOD,   4'd0,  32'h0,         1'b0, 1'b1, KIND_ACK,  32'hFFFF_FFFF, STATUS_OK},
        '{OP_INIT,         4'd15, 32'h0,         1'b1, 1'b1, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_START,        4'd15, 32'h0,         1'b0, 1'b0, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_START,        4'd0,  32'h0,         1'b0, 1'b0, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_TICK,         4'd0,  32'h0,         1'b0, 1'b0, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_GET_STATE,    4'd0,  32'h0,         1'b0, 1'b0, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_TICK,         4'd0,  32'h0,         1'b0, 1'b0, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_SET_ONESHOT,  4'd15, 32'h0,         1'b0, 1'b1, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_TICK,         4'd0,  32'h0,         1'b0, 1'b0, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_TICK,         4'd0,  32'h0,         1'b0, 1'b0, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_STOP,         4'd15, 32'h0,         1'b0, 1'b1, KIND_ACK,       32'h0, STATUS_ERR},
        '{OP_SET_PERIOD,   4'd7,  32'h8000_0000, 1'b0, 1'b1, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_SET_PERIODIC, 4'd7,  32'h0,         1'b0, 1'b1, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_GET_PERIOD,   4'd7,  32'h0,         1'b0, 1'b1, KIND_ACK,  32'h8000_0000, STATUS_OK},
        '{OP_DELETE,       4'd15, 32'h0,         1'b0, 1'b1, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_UNUSED_LO,    4'd5,  32'h5A5A_A5A5, 1'b1, 1'b1, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_UNUSED_HI,    4'd10, 32'hFFFF_FFFF, 1'b1, 1'b1, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_INIT,         4'd3,  32'h2,         1'b1, 1'b1, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_START,        4'd3,  32'h0,         1'b0, 1'b0, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_STOP,         4'd3,  32'h0,         1'b0, 1'b0, KIND_ACK,       32'h0, STATUS_OK},
        '{OP_SET_PERIOD,   4'd12, 32'h1,         1'b0, 1'b1, KIND_ACK,       32'h0, STATUS_OK}
    };

    logic clk = 1'b0;
    logic rst_n;

    mtt_cmd_if cmd_ch ();
    mtt_res_if res_ch ();

    multi_timer_table_engine uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .res   (res_ch.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // timer table model
    logic [31:0]           tick_now;
    logic [31:0]           period_mem   [NUM_TIMERS];
    logic [31:0]           deadline_mem [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] active_map;
    logic [NUM_TIMERS-1:0] periodic_map;
    logic [NUM_TIMERS-1:0] armed_map;
    logic [NUM_TIMERS-1:0] period_set;

    timer_result_t pending_results [$];

    int  src_idle_pct;
    int  snk_idle_pct;
    bit  hold_req;
    int  mismatch_count;
    int  beats_sent;
    int  results_seen;
    int  expiries_seen;
    int  idle_ticks_seen;

    function automatic void post_result(mtt_kind_t kind, logic [3:0] index,
                                        logic [31:0] read_value, logic status, logic last);
        timer_result_t r;
        r.kind       = kind;
        r.index      = index;
        r.read_value = read_value;
        r.status     = status;
        r.last       = last;
        pending_results.push_back(r);
    endfunction

    function automatic void timer_table_step(cmd_beat_t b, bit post);
        logic [NUM_TIMERS-1:0] fired;
        int                    n_fired;
        int                    k;
        logic [31:0]           rv;
        logic                  st;
        fired   = '0;
        n_fired = 0;
        k       = 0;
        rv      = '0;
        st      = STATUS_OK;
        if (b.op == OP_TICK)
        begin
            tick_now = tick_now + 32'd1;
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                if (armed_map[t] && tick_now >= deadline_mem[t])
                begin
                    if (active_map[t] && n_fired < MAX_REPORTS)
                    begin
                        fired[t] = 1'b1;
                        n_fired++;
                    end
                    if (periodic_map[t])
                    begin
                        deadline_mem[t] = tick_now + period_mem[t];
                        active_map[t]   = 1'b1;
                    end
                    else
                        active_map[t] = 1'b0;
                end
            end
            if (post && n_fired == 0)
                post_result(KIND_IDLE_TICK, 4'd0, 32'h0, STATUS_OK, 1'b1);
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                if (post && fired[t])
                begin
                    k++;
                    post_result(KIND_EXPIRY, 4'(t), 32'h0, STATUS_OK, k == n_fired);
                end
            end
        end
        else
        begin
            case (b.op)
                OP_INIT:
                begin
                    period_mem[b.index]   = b.value;
                    deadline_mem[b.index] = '0;
                    periodic_map[b.index] = b.mode;
                    active_map[b.index]   = 1'b0;
                    armed_map[b.index]    = 1'b0;
                    period_set[b.index]   = 1'b1;
                end
                OP_START:
                begin
                    deadline_mem[b.index] = tick_now + period_mem[b.index];
                    active_map[b.index]   = 1'b1;
                    armed_map[b.index]    = 1'b1;
                end
                OP_STOP:
                begin
                    if (!active_map[b.index])
                        st = STATUS_ERR;
                    else
                    begin
                        active_map[b.index] = 1'b0;
                        armed_map[b.index]  = 1'b0;
                    end
                end
                OP_DELETE:
                begin
                    active_map[b.index] = 1'b0;
                    armed_map[b.index]  = 1'b0;
                end
                OP_SET_PERIOD:
                begin
                    period_mem[b.index] = b.value;
                    period_set[b.index] = 1'b1;
                end
                OP_SET_ONESHOT:  periodic_map[b.index] = 1'b0;
                OP_SET_PERIODIC: periodic_map[b.index] = 1'b1;
                OP_GET_PERIOD:   rv = period_mem[b.index];
                OP_GET_STATE:    rv = {31'h0, active_map[b.index]};
                OP_READ_TICK:    rv = tick_now;
                default: ;
            endcase
            if (post)
                post_result(KIND_ACK, b.index, rv, st, 1'b1);
        end
    endfunction

    // period must be written before a start or a period read touches it
    function automatic cmd_beat_t random_beat();
        cmd_beat_t b;
        int        r;
        int        v;
        r       = $urandom_range(99);
        v       = $urandom_range(99);
        b.index = 4'($urandom_range(NUM_TIMERS - 1));
        b.mode  = 1'($urandom_range(1));
        if (v < 75)
            b.value = 32'($urandom_range(5));
        else if (v < 90)
            b.value = $urandom;
        else
            b.value = (v < 95) ? 32'hFFFF_FFFF : 32'h0;
        if      (r < 30) b.op = OP_TICK;
        else if (r < 42) b.op = OP_INIT;
        else if (r < 56) b.op = OP_START;
        else if (r < 64) b.op = OP_STOP;
        else if (r < 69) b.op = OP_DELETE;
        else if (r < 76) b.op = OP_SET_PERIOD;
        else if (r < 80) b.op = OP_SET_ONESHOT;
        else if (r < 84) b.op = OP_SET_PERIODIC;
        else if (r < 89) b.op = OP_GET_PERIOD;
        else if (r < 94) b.op = OP_GET_STATE;
        else if (r < 97) b.op = OP_READ_TICK;
        else             b.op = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        if ((b.op == OP_START || b.op == OP_GET_PERIOD) && !period_set[b.index])
            b.op = OP_INIT;
        return b;
    endfunction

    task automatic send_beat(cmd_beat_t b, bit typed, timer_result_t typed_res);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.operation     <= b.op;
        cmd_ch.timer_index   <= b.index;
        cmd_ch.value         <= b.value;
        cmd_ch.periodic_mode <= b.mode;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        beats_sent++;
        timer_table_step(b, !typed);
        if (typed)
            pending_results.push_back(typed_res);
    endtask

    task automatic send_random(int count);
        timer_result_t none;
        none = '0;
        repeat (count)
            send_beat(random_beat(), 1'b0, none);
    endtask

    // result side: ready pattern, long hold on request, in-order check
    initial
    begin
        timer_result_t want;
        int            hold_left;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (res_ch.kind == KIND_EXPIRY)
                    expiries_seen++;
                if (res_ch.kind == KIND_IDLE_TICK)
                    idle_ticks_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("result beat with nothing expected: kind %0d timer %0d",
                           res_ch.kind, res_ch.timer_index_res);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (res_ch.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, res_ch.kind);
                        mismatch_count++;
                    end
                    if (res_ch.timer_index_res !== want.index)
                    begin
                        $error("timer_index_res: expected %0d, got %0d",
                               want.index, res_ch.timer_index_res);
                        mismatch_count++;
                    end
                    if (res_ch.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %h, got %h",
                               want.read_value, res_ch.read_value);
                        mismatch_count++;
                    end
                    if (res_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, res_ch.status);
                        mismatch_count++;
                    end
                    if (res_ch.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, res_ch.last);
                        mismatch_count++;
                    end
                end
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial
    begin
        int stalled;
        stalled = 0;
        forever
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                stalled = 0;
            else
                stalled++;
            if (stalled >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles, %0d results outstanding",
                         stalled, pending_results.size());
                $display("tb_multi_timer_table_engine: errors");
                $finish;
            end
        end
    end

    initial
    begin
        cmd_beat_t     b;
        timer_result_t r;
        rst_n                = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.operation     = OP_TICK;
        cmd_ch.timer_index   = '0;
        cmd_ch.value         = '0;
        cmd_ch.periodic_mode = 1'b0;
        src_idle_pct         = 24;
        snk_idle_pct         = 54;
        hold_req             = 1'b0;
        mismatch_count       = 0;
        beats_sent           = 0;
        results_seen         = 0;
        expiries_seen        = 0;
        idle_ticks_seen      = 0;
        tick_now             = '0;
        active_map           = '0;
        periodic_map         = '0;
        armed_map            = '0;
        period_set           = '0;
        for (int t = 0; t < NUM_TIMERS; t++)
        begin
            period_mem[t]   = '0;
            deadline_mem[t] = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            b.op         = directed_rows[i].op;
            b.index      = directed_rows[i].index;
            b.value      = directed_rows[i].value;
            b.mode       = directed_rows[i].mode;
            r.kind       = directed_rows[i].kind;
            r.index      = (directed_rows[i].kind == KIND_IDLE_TICK) ? 4'd0 : b.index;
            r.read_value = directed_rows[i].read_value;
            r.status     = directed_rows[i].status;
            r.last       = 1'b1;
            send_beat(b, directed_rows[i].typed, r);
        end

        send_random(20);

        src_idle_pct = 54;
        snk_idle_pct = 24;
        // every timer periodic with a zero or unit period: each tick fires all
        r = '0;
        for (int t = 0; t < NUM_TIMERS; t++)
        begin
            b.op    = OP_INIT;
            b.index = 4'(t);
            b.value = 32'($urandom_range(1));
            b.mode  = 1'b1;
            send_beat(b, 1'b0, r);
        end
        for (int t = 0; t < NUM_TIMERS; t++)
        begin
            b.op    = OP_START;
            b.index = 4'(t);
            b.value = $urandom;
            send_beat(b, 1'b0, r);
        end
        b.op = OP_TICK;
        repeat (3) send_beat(b, 1'b0, r);
        send_random(10);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req     = 1'b1;
        send_random(20);

        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d command/tick beats, %0d results (%0d expiries, %0d idle ticks)",
                 beats_sent, results_seen, expiries_seen, idle_ticks_seen);
        $display("final tick count %0d, %0d field mismatches", tick_now, mismatch_count);
        if (mismatch_count == 0)
            $display("tb_multi_timer_table_engine: clean");
        else
            $display("tb_multi_timer_table_engine: errors");
        $finish;
    end

endmodule
